[design/ic_pkg.sv]
// Shared types and constants for the inversion counter.
`default_nettype none

package ic_pkg;

	// Fixed port field widths
	localparam int VALUE_W = 32;
	localparam int TOTAL_W = 19;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	// Parameter defaults
	localparam int MAX_ITEMS_DEF  = 1024;
	localparam int VALUE_BITS_DEF = 32;

	// Input word
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} in_word_t;

	// Output word
	typedef struct packed {
		logic [TOTAL_W-1:0] running_total;
		logic               done_res;
		logic               overflow;
	} out_word_t;

	// Control flags that travel with a probe down the cell chain
	typedef struct packed {
		logic valid;    // slot holds a live probe
		logic last;     // final element: clears each cell it passes
		logic present;  // an equal value was found upstream
		logic placed;   // a free cell was claimed upstream
	} probe_ctl_t;

endpackage

`default_nettype wire

[design/ic_cell.sv]
// One storage cell of the chain: holds one distinct value and grades passing probes.
`default_nettype none

module ic_cell #(
	parameter int CMP_W = 32,
	parameter int CNT_W = 11
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     run,
	input  ic_pkg::probe_ctl_t      ctl_in,
	input  wire signed [CMP_W-1:0]  val_in,
	input  wire        [CNT_W-1:0]  cnt_in,
	output ic_pkg::probe_ctl_t      ctl_out,
	output logic signed [CMP_W-1:0] val_out,
	output logic       [CNT_W-1:0]  cnt_out
);
	import ic_pkg::*;

	logic signed [CMP_W-1:0] stored_q;
	logic                    held_q;
	probe_ctl_t              ctl_q;
	logic                    hit_less;
	logic                    hit_eq;
	logic                    claim;
	probe_ctl_t              ctl_nxt;

	// Compare the probe with the held value
	always_comb begin
		hit_less = ctl_in.valid && held_q && (stored_q < val_in);
		hit_eq   = ctl_in.valid && held_q && (stored_q == val_in);
		// first free cell takes a new distinct value
		claim    = ctl_in.valid && !held_q && !ctl_in.present && !ctl_in.placed;
		ctl_nxt         = ctl_in;
		ctl_nxt.present = ctl_in.present | hit_eq;
		ctl_nxt.placed  = ctl_in.placed | claim;
	end

	// Cell contents: a final probe empties the cell behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
		end else if (run && ctl_in.valid) begin
			if (ctl_in.last) begin
				held_q <= 1'b0;
			end else if (claim) begin
				held_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run && claim && !ctl_in.last) begin
			stored_q <= val_in;
		end
	end

	// Hand the probe to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (run) begin
			ctl_q <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			val_out <= val_in;
			cnt_out <= cnt_in + CNT_W'(hit_less);
		end
	end

	assign ctl_out = ctl_q;

endmodule

`default_nettype wire

[design/ic_tail.sv]
// End of the chain: running total, overflow flag and the output register with skid stage.
`default_nettype none

module ic_tail #(
	parameter int CNT_W = 11
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  ic_pkg::probe_ctl_t     ctl_in,
	input  wire [CNT_W-1:0]        cnt_in,
	output logic                   run,
	output logic                   result_valid,
	input  wire                    result_ready,
	output ic_pkg::out_word_t      result
);
	import ic_pkg::*;

	logic [TOTAL_W-1:0] total_q;
	logic               ovf_q;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] new_total;
	logic               ovf_now;
	out_word_t          word;
	logic               push;
	logic               take;
	out_word_t          out_q;
	logic               out_valid_q;
	out_word_t          skid_q;
	logic               skid_valid_q;

	// Saturating add of this probe's count
	always_comb begin
		sum       = {1'b0, total_q} + (TOTAL_W + 1)'(cnt_in);
		new_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
		ovf_now   = ovf_q | (!ctl_in.present && !ctl_in.placed);
		word.running_total = new_total;
		word.done_res      = ctl_in.last;
		word.overflow      = ovf_now;
	end

	assign run  = !skid_valid_q;
	assign push = run && ctl_in.valid;
	assign take = out_valid_q && result_ready;

	// Per-sequence totals, cleared after the final word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			ovf_q   <= 1'b0;
		end else if (push) begin
			total_q <= ctl_in.last ? '0 : new_total;
			ovf_q   <= ctl_in.last ? 1'b0 : ovf_now;
		end
	end

	// Output register plus skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || take) begin
				out_q <= word;
			end else begin
				skid_q <= word;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

[design/inversion_counter.sv]
// Top level of the inversion counter: a systolic row of value cells and the result tail.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+---------------------------------------
//   item     | item_valid / item_ready     | value, last
//   result   | result_valid / result_ready | running_total, done_res, overflow
//
// One word enters per cycle while item_ready is high. A result becomes valid once its
// word has crossed the chain: the word lands in cell 0 on the accepting edge, moves one
// cell per cycle while the chain runs, and the output register takes it from the last cell.
// Reset clears every cell's occupancy bit at once; no clearing pass is needed.
// A final word empties each cell as it passes, so the next sequence may follow directly.
// While the skid stage holds a word the whole chain freezes and item_ready is low.
`default_nettype none

module inversion_counter #(
	parameter int MAX_ITEMS  = ic_pkg::MAX_ITEMS_DEF,
	parameter int VALUE_BITS = ic_pkg::VALUE_BITS_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	output logic               item_ready,
	input  ic_pkg::in_word_t   item,
	output logic               result_valid,
	input  wire                result_ready,
	output ic_pkg::out_word_t  result
);
	import ic_pkg::*;

	localparam int CMP_W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	logic                    run;
	probe_ctl_t              ctl_c [MAX_ITEMS+1];
	logic signed [CMP_W-1:0] val_c [MAX_ITEMS+1];
	logic        [CNT_W-1:0] cnt_c [MAX_ITEMS+1];

	// Probe entering the chain
	assign ctl_c[0].valid   = item_valid;
	assign ctl_c[0].last    = item.last;
	assign ctl_c[0].present = 1'b0;
	assign ctl_c[0].placed  = 1'b0;
	assign val_c[0]         = item.value[CMP_W-1:0];
	assign cnt_c[0]         = '0;

	assign item_ready = run;

	// Cell chain
	for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
		ic_cell #(
			.CMP_W(CMP_W),
			.CNT_W(CNT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.run    (run),
			.ctl_in (ctl_c[g]),
			.val_in (val_c[g]),
			.cnt_in (cnt_c[g]),
			.ctl_out(ctl_c[g+1]),
			.val_out(val_c[g+1]),
			.cnt_out(cnt_c[g+1])
		);
	end

	// Total, overflow and output stage
	ic_tail #(
		.CNT_W(CNT_W)
	) u_tail (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl_in      (ctl_c[MAX_ITEMS]),
		.cnt_in      (cnt_c[MAX_ITEMS]),
		.run         (run),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

`default_nettype wire

[design/ic_checker.sv]
// Port-level checks for the inversion counter, bound to the top level.
`default_nettype none

module ic_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               item_valid,
	input wire               item_ready,
	input ic_pkg::in_word_t  item,
	input wire               result_valid,
	input wire               result_ready,
	input ic_pkg::out_word_t result
);
	import ic_pkg::*;

	logic               item_take;
	logic               res_take;
	logic [23:0]        inflight_q;
	logic               prev_done_q;
	logic               prev_ovf_q;
	logic [TOTAL_W-1:0] prev_total_q;

	assign item_take = item_valid && item_ready;
	assign res_take  = result_valid && result_ready;

	// Words accepted but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 24'(item_take) - 24'(res_take);
		end
	end

	// Last delivered result; a sequence starts fresh after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_done_q  <= 1'b1;
			prev_ovf_q   <= 1'b0;
			prev_total_q <= '0;
		end else if (res_take) begin
			prev_done_q  <= result.done_res;
			prev_ovf_q   <= result.overflow;
			prev_total_q <= result.running_total;
		end
	end

	// An offered word stays put until taken
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(item))
		else $error("input word changed while stalled");

	// A held result stays put until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// No result without an outstanding word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> inflight_q != '0)
		else $error("result with no word in flight");

	// Within a sequence the total never drops
	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && !prev_done_q |-> result.running_total >= prev_total_q)
		else $error("running total decreased within a sequence");

	// Overflow stays set until the sequence ends
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_take && !prev_done_q && prev_ovf_q |-> result.overflow)
		else $error("overflow flag dropped within a sequence");

endmodule

bind inversion_counter ic_checker u_ic_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_ready  (item_ready),
	.item        (item),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);

`default_nettype wire
